// File: rtl/stt_pkg.sv
// Shared types and constants of the source text tokenizer.
// Used by stt_front, stt_back, the top level and the checker.
package stt_pkg;

  localparam int MaxTokenLen = 1023;
  localparam int PosBits     = 32;

  localparam logic [9:0] LEN_CAP = 10'((MaxTokenLen < 1023) ? MaxTokenLen : 1023);

  localparam logic [2:0] KIND_IDENT   = 3'd0;
  localparam logic [2:0] KIND_KEYWORD = 3'd1;
  localparam logic [2:0] KIND_NUMBER  = 3'd2;
  localparam logic [2:0] KIND_STRING  = 3'd3;
  localparam logic [2:0] KIND_PUNCT   = 3'd4;
  localparam logic [2:0] KIND_OPER    = 3'd5;
  localparam logic [2:0] KIND_END     = 3'd6;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam int NumKw = 3;
  localparam logic [2:0] KW_LEN [NumKw] = '{3'd5, 3'd5, 3'd4};

  // Keyword spelling: print, while, func; zero past the end of a word.
  function automatic logic [7:0] kw_char(input int k, input int j);
    logic [7:0] c;
    c = 8'd0;
    unique case (k)
      0: begin
        unique case (j)
          0: c = "p";
          1: c = "r";
          2: c = "i";
          3: c = "n";
          4: c = "t";
          default: c = 8'd0;
        endcase
      end
      1: begin
        unique case (j)
          0: c = "w";
          1: c = "h";
          2: c = "i";
          3: c = "l";
          4: c = "e";
          default: c = 8'd0;
        endcase
      end
      default: begin
        unique case (j)
          0: c = "f";
          1: c = "u";
          2: c = "n";
          3: c = "c";
          default: c = 8'd0;
        endcase
      end
    endcase
    return c;
  endfunction

  typedef struct packed {
    logic space;
    logic idstart;
    logic digit;
    logic word;
    logic quote;
    logic bslash;
    logic punct;
    logic pairop;
    logic eq;
    logic [NumKw-1:0][7:0] kw_eq;
  } class_t;

  typedef struct packed {
    logic   cmd;
    class_t cls;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  kwi;
    logic [31:0] start;
    logic [9:0]  len;
    logic        unterm;
    logic        trunc;
    logic        last;
  } res_t;

endpackage

// File: rtl/stt_front.sv
// Front end of the tokenizer: classifies each input byte and queues it.
// Depends on stt_pkg.
module stt_front import stt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic [7:0] ch_i,
  output logic       item_valid_o,
  output item_t      item_o,
  input  logic       item_pop_i
);

  item_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  item_t      cls_item;
  logic       push, pop;

  always_comb begin
    logic alpha, dig;
    alpha = (ch_i >= "a" && ch_i <= "z") || (ch_i >= "A" && ch_i <= "Z");
    dig   = ch_i >= "0" && ch_i <= "9";
    cls_item.cmd         = cmd_i;
    cls_item.cls.space   = (ch_i == 8'd32) || (ch_i >= 8'd9 && ch_i <= 8'd13);
    cls_item.cls.idstart = alpha || ch_i == "_";
    cls_item.cls.digit   = dig;
    cls_item.cls.word    = alpha || dig || ch_i == "_";
    cls_item.cls.quote   = ch_i == "\"";
    cls_item.cls.bslash  = ch_i == "\\";
    cls_item.cls.punct   = ch_i == ";" || ch_i == "," || ch_i == "(" || ch_i == ")" ||
                           ch_i == "{" || ch_i == "}" || ch_i == 8'd0;
    cls_item.cls.pairop  = ch_i == "=" || ch_i == "!" || ch_i == "<" || ch_i == ">";
    cls_item.cls.eq      = ch_i == "=";
    for (int k = 0; k < NumKw; k++) begin
      for (int j = 0; j < 8; j++) begin
        cls_item.cls.kw_eq[k][j] = (j < int'(KW_LEN[k])) && (ch_i == kw_char(k, j));
      end
    end
  end

  assign in_ready_o   = cnt_q != 2'd2;
  assign item_valid_o = cnt_q != 2'd0;
  assign item_o       = mem_q[rptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_pop_i && item_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (!push && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= cls_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/stt_back.sv
// Back end of the tokenizer: scanner state machine and result queue.
// Depends on stt_pkg; fed by stt_front.
module stt_back import stt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  item_valid_i,
  input  item_t item_i,
  output logic  item_pop_o,
  output logic  res_valid_o,
  output res_t  res_o,
  input  logic  res_ready_i
);

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_IDENT  = 3'd1;
  localparam logic [2:0] MODE_NUMBER = 3'd2;
  localparam logic [2:0] MODE_STRING = 3'd3;
  localparam logic [2:0] MODE_ESCAPE = 3'd4;
  localparam logic [2:0] MODE_OPER   = 3'd5;

  logic [2:0]         mode_q, mode_d;
  logic [PosBits-1:0] pos_q, pos_d, start_q, start_d;
  logic [9:0]         len_q, len_d;
  logic [NumKw-1:0]   kw_q, kw_d;
  logic               sat_q, sat_d;

  res_t       mem_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] cnt_q, cnt_d;
  logic       va, vb, take, pop_out;
  res_t       ra, rb;

  function automatic res_t mk_res(input logic [2:0] kind, input logic [1:0] kwi,
                                  input logic [PosBits-1:0] p, input logic [9:0] len,
                                  input logic unterm, input logic trunc);
    res_t r;
    r.kind   = kind;
    r.kwi    = kwi;
    r.start  = 32'(p);
    r.len    = len;
    r.unterm = unterm;
    r.trunc  = trunc;
    r.last   = 1'b0;
    return r;
  endfunction

  // Take an item only when the result queue can absorb two beats.
  assign take       = item_valid_i && (cnt_q <= 3'd2);
  assign item_pop_o = take;

  always_comb begin
    class_t     c;
    logic       rescan, fv;
    res_t       fr, wr;
    logic [2:0] wkind;
    logic [1:0] wkwi;
    logic [9:0] g1_len, g2_len;
    logic       g1_sat, g2_sat;

    c      = item_i.cls;
    mode_d = mode_q;
    pos_d  = pos_q;
    start_d = start_q;
    len_d  = len_q;
    kw_d   = kw_q;
    sat_d  = sat_q;
    va     = 1'b0;
    vb     = 1'b0;
    ra     = '0;
    rb     = '0;
    rescan = 1'b0;
    fv     = 1'b0;
    fr     = '0;

    if (len_q < LEN_CAP) begin
      g1_len = len_q + 10'd1;
      g1_sat = sat_q;
    end else begin
      g1_len = len_q;
      g1_sat = 1'b1;
    end
    if (len_q < LEN_CAP - 10'd1) begin
      g2_len = len_q + 10'd2;
      g2_sat = sat_q;
    end else begin
      g2_len = LEN_CAP;
      g2_sat = 1'b1;
    end

    // Result for a word token ending here; a saturated ident is never a keyword.
    wkind = (mode_q == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
    wkwi  = 2'd0;
    if (mode_q == MODE_IDENT && !sat_q) begin
      for (int k = 0; k < NumKw; k++) begin
        if (kw_q[k] && len_q == {7'd0, KW_LEN[k]}) begin
          wkind = KIND_KEYWORD;
          wkwi  = 2'(k);
        end
      end
    end
    wr = mk_res(wkind, wkwi, start_q, len_q, 1'b0, sat_q);

    if (item_i.cmd == CMD_END) begin
      unique case (mode_q)
        MODE_IDENT, MODE_NUMBER: begin
          va = 1'b1;
          ra = wr;
        end
        MODE_STRING, MODE_ESCAPE: begin
          va = 1'b1;
          ra = mk_res(KIND_STRING, 2'd0, start_q, len_q, 1'b1, sat_q);
        end
        MODE_OPER: begin
          va = 1'b1;
          ra = mk_res(KIND_OPER, 2'd0, start_q, 10'd1, 1'b0, 1'b0);
        end
        default: ;
      endcase
      if (va) begin
        vb = 1'b1;
        rb = mk_res(KIND_END, 2'd0, pos_q, 10'd0, 1'b0, 1'b0);
      end else begin
        va = 1'b1;
        ra = mk_res(KIND_END, 2'd0, pos_q, 10'd0, 1'b0, 1'b0);
      end
      mode_d  = MODE_IDLE;
      pos_d   = '0;
      start_d = '0;
      len_d   = 10'd0;
      kw_d    = '1;
      sat_d   = 1'b0;
    end else begin
      pos_d = pos_q + PosBits'(1);
      unique case (mode_q)
        MODE_IDENT: begin
          if (c.word) begin
            for (int k = 0; k < NumKw; k++) begin
              kw_d[k] = kw_q[k] && (len_q < {7'd0, KW_LEN[k]}) && c.kw_eq[k][len_q[2:0]];
            end
            len_d = g1_len;
            sat_d = g1_sat;
          end else begin
            va     = 1'b1;
            ra     = wr;
            mode_d = MODE_IDLE;
            rescan = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (c.digit) begin
            len_d = g1_len;
            sat_d = g1_sat;
          end else begin
            va     = 1'b1;
            ra     = wr;
            mode_d = MODE_IDLE;
            rescan = 1'b1;
          end
        end
        MODE_STRING: begin
          if (c.quote) begin
            len_d  = g1_len;
            sat_d  = g1_sat;
            va     = 1'b1;
            ra     = mk_res(KIND_STRING, 2'd0, start_q, g1_len, 1'b0, g1_sat);
            mode_d = MODE_IDLE;
          end else if (c.bslash) begin
            mode_d = MODE_ESCAPE;
          end else begin
            len_d = g1_len;
            sat_d = g1_sat;
          end
        end
        MODE_ESCAPE: begin
          // The backslash and the escaped byte count together.
          len_d  = g2_len;
          sat_d  = g2_sat;
          mode_d = MODE_STRING;
        end
        MODE_OPER: begin
          va     = 1'b1;
          mode_d = MODE_IDLE;
          if (c.eq) begin
            ra = mk_res(KIND_OPER, 2'd0, start_q, 10'd2, 1'b0, 1'b0);
          end else begin
            ra     = mk_res(KIND_OPER, 2'd0, start_q, 10'd1, 1'b0, 1'b0);
            rescan = 1'b1;
          end
        end
        default: begin
          mode_d = MODE_IDLE;
          rescan = 1'b1;
        end
      endcase

      // Scan the byte afresh once any earlier token has been closed.
      if (rescan) begin
        priority if (c.space) begin
          fv = 1'b0;
        end else if (c.idstart) begin
          start_d = pos_q;
          len_d   = 10'd1;
          sat_d   = 1'b0;
          for (int k = 0; k < NumKw; k++) kw_d[k] = c.kw_eq[k][0];
          mode_d  = MODE_IDENT;
        end else if (c.digit) begin
          start_d = pos_q;
          len_d   = 10'd1;
          sat_d   = 1'b0;
          kw_d    = '1;
          mode_d  = MODE_NUMBER;
        end else if (c.quote) begin
          start_d = pos_q;
          len_d   = 10'd1;
          sat_d   = 1'b0;
          kw_d    = '1;
          mode_d  = MODE_STRING;
        end else if (c.punct) begin
          fv = 1'b1;
          fr = mk_res(KIND_PUNCT, 2'd0, pos_q, 10'd1, 1'b0, 1'b0);
        end else if (c.pairop) begin
          start_d = pos_q;
          len_d   = 10'd1;
          sat_d   = 1'b0;
          kw_d    = '1;
          mode_d  = MODE_OPER;
        end else begin
          fv = 1'b1;
          fr = mk_res(KIND_OPER, 2'd0, pos_q, 10'd1, 1'b0, 1'b0);
        end
        if (fv) begin
          if (va) begin
            vb = 1'b1;
            rb = fr;
          end else begin
            va = 1'b1;
            ra = fr;
          end
        end
      end
    end

    if (vb) rb.last = 1'b1;
    else ra.last = 1'b1;
  end

  assign res_valid_o = cnt_q != 3'd0;
  assign res_o       = mem_q[rptr_q];
  assign pop_out     = res_valid_o && res_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (take && va) cnt_d = cnt_d + 3'd1;
    if (take && vb) cnt_d = cnt_d + 3'd1;
    if (pop_out)    cnt_d = cnt_d - 3'd1;
  end

  always_ff @(posedge clk_i) begin
    if (take && va) mem_q[wptr_q] <= ra;
    if (take && vb) mem_q[wptr_q + 2'd1] <= rb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= 10'd0;
      kw_q    <= '1;
      sat_q   <= 1'b0;
      wptr_q  <= 2'd0;
      rptr_q  <= 2'd0;
      cnt_q   <= 3'd0;
    end else begin
      if (take) begin
        mode_q  <= mode_d;
        pos_q   <= pos_d;
        start_q <= start_d;
        len_q   <= len_d;
        kw_q    <= kw_d;
        sat_q   <= sat_d;
        wptr_q  <= wptr_q + {1'b0, va} + {1'b0, vb};
      end
      if (pop_out) rptr_q <= rptr_q + 2'd1;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/source_text_tokenizer.sv
// Top level of the source text tokenizer.
// Instantiates stt_front and stt_back; depends on stt_pkg.
//
// Input channel: one beat per source byte (cmd_i = 0, byte on ch_i) or an
// end-of-input beat (cmd_i = 1). Output channel: one beat per token with
// kind, keyword index, start offset, length, unterminated and truncated
// flags; last_o marks the final token caused by one input beat.
// An input beat may cause zero, one or two tokens; end of input always
// gives an end marker and returns the scanner to offset zero.
// A token passes the registered input queue and then the registered
// result queue before it is valid on the output. Throughput: one input
// beat per cycle while each beat yields at most one token and the
// receiver does not stall; a beat that yields two tokens slows the flow,
// since the output port delivers one token a cycle.
// A two-entry input queue and a four-entry result queue decouple the sides:
// when the receiver stalls, results collect, the scanner stops once three
// tokens wait (no room left for a two-token beat), and in_ready_o falls once
// the input queue is full as well. Reset clears both queues and the scanner
// state.
module source_text_tokenizer import stt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  token_kind_o,
  output logic [1:0]  keyword_index_o,
  output logic [31:0] start_offset_o,
  output logic [9:0]  token_length_o,
  output logic        unterminated_o,
  output logic        truncated_o,
  output logic        last_o
);

  item_t item;
  logic  item_valid, item_pop;
  res_t  res;

  stt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .ch_i         (ch_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  stt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_valid_o  (out_valid_o),
    .res_o        (res),
    .res_ready_i  (out_ready_i)
  );

  assign token_kind_o    = res.kind;
  assign keyword_index_o = res.kwi;
  assign start_offset_o  = res.start;
  assign token_length_o  = res.len;
  assign unterminated_o  = res.unterm;
  assign truncated_o     = res.trunc;
  assign last_o          = res.last;

endmodule

// File: rtl/stt_checker.sv
// Port-level checks of the source text tokenizer, bound to the top level.
// Depends on stt_pkg.
module stt_checker import stt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  token_kind_o,
  input logic [1:0]  keyword_index_o,
  input logic [9:0]  token_length_o,
  input logic        unterminated_o,
  input logic        last_o
);

  // A stalled result beat holds until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_kind_o) &&
    $stable(token_length_o))
    else $error("stalled result beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == KIND_END |-> last_o && token_length_o == 10'd0)
    else $error("end marker without last or with length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unterminated_o |-> token_kind_o == KIND_STRING)
    else $error("unterminated flag on a non-string token");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o != KIND_KEYWORD |-> keyword_index_o == 2'd0)
    else $error("keyword index on a non-keyword token");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o != KIND_END |-> token_length_o != 10'd0)
    else $error("empty token");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .token_kind_o    (token_kind_o),
  .keyword_index_o (keyword_index_o),
  .token_length_o  (token_length_o),
  .unterminated_o  (unterminated_o),
  .last_o          (last_o)
);
